/* src/i2cram_pkg.sv */
// shared types and constants of the i2c register access master
package i2cram_pkg;

  // configuration port
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 16;

  // stream payload widths, data padded to whole bytes
  localparam int unsigned SDataW = 24;
  localparam int unsigned MDataW = 16;
  localparam int unsigned SUserW = 2;

  // transaction kinds carried in the request tuser
  localparam logic [1:0] ActTick  = 2'd0;
  localparam logic [1:0] ActWrite = 2'd1;
  localparam logic [1:0] ActRead  = 2'd2;

  // register reset values
  localparam logic [6:0]  DevAddrRst = 7'd104;
  localparam logic [15:0] TicksRst   = 16'd250;
  localparam logic [7:0]  AckLimRst  = 8'd250;

  // configuration register set
  typedef struct packed {
    logic [6:0]  device_address;
    logic [15:0] ticks_per_phase;
    logic [7:0]  ack_timeout_limit;
  } cfg_t;

  // one result item, scl_level in the lowest bit
  typedef struct packed {
    logic       ack_error;
    logic [7:0] read_data;
    logic       done_res;
    logic       busy_res;
    logic       sda_pull_low;
    logic       scl_level;
  } res_t;

  localparam int unsigned ResW = $bits(res_t);

endpackage

/* src/i2cram_cfg.sv */
// configuration register file
module i2cram_cfg (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [i2cram_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [i2cram_pkg::CfgDataW-1:0]  cfg_data_i,
  output i2cram_pkg::cfg_t                 cfg_o
);
  import i2cram_pkg::*;

  localparam logic [CfgIdxW-1:0] IdxDevAddr = 2'd0;
  localparam logic [CfgIdxW-1:0] IdxTicks   = 2'd1;
  localparam logic [CfgIdxW-1:0] IdxAckLim  = 2'd2;

  cfg_t cfg_q, cfg_d;
  logic wr_en;

  assign cfg_ready_o = 1'b1;
  assign wr_en       = cfg_valid_i;

  // decode register writes, unknown indexes are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (cfg_index_i)
        IdxDevAddr: cfg_d.device_address    = cfg_data_i[6:0];
        IdxTicks:   cfg_d.ticks_per_phase   = cfg_data_i;
        IdxAckLim:  cfg_d.ack_timeout_limit = cfg_data_i[7:0];
        default:    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.device_address    <= DevAddrRst;
      cfg_q.ticks_per_phase   <= TicksRst;
      cfg_q.ack_timeout_limit <= AckLimRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* src/i2cram_core.sv */
// bus sequencer: state registers and one-tick next-state logic
module i2cram_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic [1:0]        action_i,
  input  logic [7:0]        reg_address_i,
  input  logic [7:0]        write_data_i,
  input  logic              sda_in_i,
  input  i2cram_pkg::cfg_t  cfg_i,
  output i2cram_pkg::res_t  res_o
);
  import i2cram_pkg::*;

  localparam logic [4:0] StIdle     = 5'd0;
  localparam logic [4:0] StStart    = 5'd1;
  localparam logic [4:0] StSendDevW = 5'd2;
  localparam logic [4:0] StAckDevW  = 5'd3;
  localparam logic [4:0] StSendReg  = 5'd4;
  localparam logic [4:0] StAckReg   = 5'd5;
  localparam logic [4:0] StSendData = 5'd6;
  localparam logic [4:0] StAckData  = 5'd7;
  localparam logic [4:0] StRestart  = 5'd8;
  localparam logic [4:0] StSendDevR = 5'd9;
  localparam logic [4:0] StAckDevR  = 5'd10;
  localparam logic [4:0] StRecv     = 5'd11;
  localparam logic [4:0] StNack     = 5'd12;
  localparam logic [4:0] StStop     = 5'd13;

  logic [4:0]  state_q, state_d;
  logic [15:0] pc_q, pc_d;
  logic [1:0]  qi_q, qi_d;
  logic [3:0]  bi_q, bi_d;
  logic [7:0]  sh_q, sh_d;
  logic [7:0]  pl_q, pl_d;
  logic [7:0]  lreg_q, lreg_d;
  logic [7:0]  ldat_q, ldat_d;
  logic        rd_q, rd_d;
  logic [7:0]  rx_q, rx_d;
  logic        err_q, err_d;
  logic        done;

  logic [15:0] plen;
  logic [16:0] pstep;
  logic        pe;
  logic [15:0] pc_adv;
  logic [1:0]  q_adv;
  logic        slot;
  logic        sample;
  logic [7:0]  sh_s;

  // one quarter-phase counter step; msb flags the end of the quarter
  function automatic logic [16:0] phase_step(input logic [15:0] cnt, input logic [15:0] len);
    logic [15:0] inc;
    inc = cnt + 16'd1;
    if (inc >= len) return {1'b1, 16'd0};
    return {1'b0, inc};
  endfunction

  // quarter and slot timing
  assign plen   = (cfg_i.ticks_per_phase == 16'd0) ? 16'd1 : cfg_i.ticks_per_phase;
  assign pstep  = phase_step(pc_q, plen);
  assign pe     = pstep[16];
  assign pc_adv = pstep[15:0];
  assign q_adv  = pe ? ((qi_q == 2'd3) ? 2'd0 : qi_q + 2'd1) : qi_q;
  assign slot   = pe && (qi_q == 2'd3);

  // receive sample on the last tick of the second quarter
  assign sample = (qi_q == 2'd1) && (({1'b0, pc_q} + 17'd1) >= {1'b0, plen});
  assign sh_s   = sample ? {sh_q[6:0], sda_in_i} : sh_q;

  // next state for one tick
  always_comb begin
    state_d = state_q;
    pc_d    = pc_q;
    qi_d    = qi_q;
    bi_d    = bi_q;
    sh_d    = sh_q;
    pl_d    = pl_q;
    lreg_d  = lreg_q;
    ldat_d  = ldat_q;
    rd_d    = rd_q;
    rx_d    = rx_q;
    err_d   = err_q;
    done    = 1'b0;
    unique case (state_q)
      StIdle: begin
        if (action_i == ActWrite || action_i == ActRead) begin
          lreg_d  = reg_address_i;
          ldat_d  = write_data_i;
          rd_d    = (action_i == ActRead);
          err_d   = 1'b0;
          state_d = StStart;
          pc_d    = '0;
          qi_d    = '0;
          bi_d    = '0;
          pl_d    = '0;
        end
      end
      StStart: begin
        pc_d = pc_adv;
        qi_d = q_adv;
        if (slot) begin
          state_d = StSendDevW;
          bi_d    = '0;
          pl_d    = '0;
          sh_d    = {cfg_i.device_address, 1'b0};
        end
      end
      StSendDevW, StSendReg, StSendData, StSendDevR: begin
        pc_d = pc_adv;
        qi_d = q_adv;
        if (slot) begin
          sh_d = {sh_q[6:0], 1'b0};
          bi_d = bi_q + 4'd1;
          if (bi_q == 4'd7) begin
            state_d = state_q + 5'd1;
            bi_d    = '0;
            pl_d    = '0;
          end
        end
      end
      StAckDevW, StAckReg, StAckData, StAckDevR: begin
        if (qi_q == 2'd2) begin
          // poll for acknowledge with scl held high
          priority if (!sda_in_i) begin
            qi_d = 2'd3;
            pc_d = '0;
          end else if (pl_q >= cfg_i.ack_timeout_limit) begin
            err_d   = 1'b1;
            state_d = StStop;
            pc_d    = '0;
            qi_d    = '0;
            bi_d    = '0;
            pl_d    = '0;
          end else begin
            pl_d = pl_q + 8'd1;
          end
        end else if (qi_q == 2'd3) begin
          pc_d = pc_adv;
          if (pe) begin
            pc_d = '0;
            qi_d = '0;
            bi_d = '0;
            pl_d = '0;
            unique case (state_q)
              StAckDevW: begin
                state_d = StSendReg;
                sh_d    = lreg_q;
              end
              StAckReg: begin
                if (rd_q) begin
                  state_d = StRestart;
                end else begin
                  state_d = StSendData;
                  sh_d    = ldat_q;
                end
              end
              StAckData: state_d = StStop;
              default: begin
                state_d = StRecv;
                sh_d    = '0;
              end
            endcase
          end
        end else begin
          pc_d = pc_adv;
          if (pe) qi_d = qi_q + 2'd1;
        end
      end
      StRestart: begin
        pc_d = pc_adv;
        qi_d = q_adv;
        if (slot) begin
          state_d = StSendDevR;
          bi_d    = '0;
          pl_d    = '0;
          sh_d    = {cfg_i.device_address, 1'b1};
        end
      end
      StRecv: begin
        sh_d = sh_s;
        pc_d = pc_adv;
        qi_d = q_adv;
        if (slot) begin
          bi_d = bi_q + 4'd1;
          if (bi_q == 4'd7) begin
            rx_d    = sh_s;
            state_d = StNack;
            bi_d    = '0;
            pl_d    = '0;
          end
        end
      end
      StNack: begin
        pc_d = pc_adv;
        qi_d = q_adv;
        if (slot) begin
          state_d = StStop;
          bi_d    = '0;
          pl_d    = '0;
        end
      end
      StStop: begin
        pc_d = pc_adv;
        qi_d = q_adv;
        if (slot) begin
          state_d = StIdle;
          bi_d    = '0;
          pl_d    = '0;
          done    = 1'b1;
        end
      end
      default: begin
        state_d = StIdle;
        pc_d    = '0;
        qi_d    = '0;
        bi_d    = '0;
        pl_d    = '0;
      end
    endcase
  end

  // line levels follow the state after this tick
  always_comb begin
    res_o.done_res  = done;
    res_o.busy_res  = (state_d != StIdle);
    res_o.read_data = rx_d;
    res_o.ack_error = err_d;
    unique case (state_d)
      StIdle: begin
        res_o.scl_level    = 1'b1;
        res_o.sda_pull_low = 1'b0;
      end
      StStart: begin
        res_o.scl_level    = (qi_d != 2'd3);
        res_o.sda_pull_low = (qi_d != 2'd0);
      end
      StSendDevW, StSendReg, StSendData, StSendDevR: begin
        res_o.scl_level    = (qi_d == 2'd1) || (qi_d == 2'd2);
        res_o.sda_pull_low = ~sh_d[7];
      end
      StRestart: begin
        res_o.scl_level    = (qi_d == 2'd1) || (qi_d == 2'd2);
        res_o.sda_pull_low = (qi_d >= 2'd2);
      end
      StStop: begin
        res_o.scl_level    = (qi_d >= 2'd2);
        res_o.sda_pull_low = (qi_d == 2'd1) || (qi_d == 2'd2);
      end
      default: begin
        res_o.scl_level    = (qi_d == 2'd1) || (qi_d == 2'd2);
        res_o.sda_pull_low = 1'b0;
      end
    endcase
  end

  // state registers advance once per accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      pc_q    <= '0;
      qi_q    <= '0;
      bi_q    <= '0;
      sh_q    <= '0;
      pl_q    <= '0;
      lreg_q  <= '0;
      ldat_q  <= '0;
      rd_q    <= 1'b0;
      rx_q    <= '0;
      err_q   <= 1'b0;
    end else if (en_i) begin
      state_q <= state_d;
      pc_q    <= pc_d;
      qi_q    <= qi_d;
      bi_q    <= bi_d;
      sh_q    <= sh_d;
      pl_q    <= pl_d;
      lreg_q  <= lreg_d;
      ldat_q  <= ldat_d;
      rd_q    <= rd_d;
      rx_q    <= rx_d;
      err_q   <= err_d;
    end
  end

`ifndef ASSERT_OFF
  // a finished transaction always leaves the block idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.done_res |-> !res_o.busy_res)
    else $error("done reported while still busy");

  // bit counter stays inside one byte
  a_bit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bi_q <= 4'd7)
    else $error("bit index past last bit");

  // while idle the slot timing is parked
  a_idle_parked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StIdle) |-> (qi_q == 2'd0 && bi_q == 4'd0 && pl_q == 8'd0))
    else $error("timing counters active while idle");

  // a new transaction clears the error flag
  a_start_clears_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (en_i && state_q == StIdle && (action_i == ActWrite || action_i == ActRead))
      |=> (state_q == StStart && !err_q))
    else $error("start did not clear error");
`endif

endmodule

/* src/i2cram_out.sv */
// result register with stream handshake
module i2cram_out (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_valid_i,
  output logic                          s_ready_o,
  input  i2cram_pkg::res_t              res_i,
  output logic                          m_valid_o,
  input  logic                          m_ready_i,
  output logic [i2cram_pkg::MDataW-1:0] m_data_o
);
  import i2cram_pkg::*;

  logic vld_q, vld_d;
  res_t res_q;
  logic load;

  // take a new result when the slot is empty or being drained
  assign s_ready_o = !vld_q || m_ready_i;
  assign load      = s_valid_i && s_ready_o;
  assign vld_d     = load ? 1'b1 : (vld_q && !m_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // payload register
  always_ff @(posedge clk_i) begin
    if (load) res_q <= res_i;
  end

  assign m_valid_o = vld_q;
  assign m_data_o  = {{(MDataW - ResW){1'b0}}, res_q};

`ifndef ASSERT_OFF
  // every accepted request shows up as a result next cycle
  a_load_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> vld_q)
    else $error("accepted request produced no result");
`endif

endmodule

/* src/i2c_register_access_master.sv */
// i2c register access master top level
// an accepted request's result is in the output register on the next cycle
// throughput: one request per cycle while m_axis_tready drains the result register; it refills while it is drained
// each request is one bus tick: scl bit time is four quarters of ticks_per_phase requests
// reset: async active low, sequencer idle, config at device 104, 250 ticks, 250 polls
module i2c_register_access_master (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [7:0] reg_address, [15:8] write_data, [16] sda_in, [23:17] zero
  input  logic [i2cram_pkg::SDataW-1:0]   s_axis_tdata,
  // [1:0] action
  input  logic [i2cram_pkg::SUserW-1:0]   s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [0] scl_level, [1] sda_pull_low, [2] busy_res, [3] done_res,
  // [11:4] read_data, [12] ack_error, [15:13] zero
  output logic [i2cram_pkg::MDataW-1:0]   m_axis_tdata,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [i2cram_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [i2cram_pkg::CfgDataW-1:0] cfg_data_i
);
  import i2cram_pkg::*;

  cfg_t cfg;
  res_t res;
  logic s_fire;

  assign s_fire = s_axis_tvalid && s_axis_tready;

  // configuration registers
  i2cram_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // bus sequencer
  i2cram_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .en_i          (s_fire),
    .action_i      (s_axis_tuser),
    .reg_address_i (s_axis_tdata[7:0]),
    .write_data_i  (s_axis_tdata[15:8]),
    .sda_in_i      (s_axis_tdata[16]),
    .cfg_i         (cfg),
    .res_o         (res)
  );

  // result register
  i2cram_out u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid),
    .s_ready_o (s_axis_tready),
    .res_i     (res),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (m_axis_tdata)
  );

endmodule

/* tb/i2c_register_access_master_tb.sv */
// testbench: i2c register access master checked tick by tick against a bus predictor
module i2c_register_access_master_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import i2cram_pkg::*;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned IdlePct    = 34;
  localparam int unsigned StallLen   = 400;
  localparam int unsigned PhaseItems = 75;
  localparam int unsigned NumPhases  = 8;
  localparam int unsigned MaxPrints  = 50;

  // register indexes on the configuration channel
  localparam logic [CfgIdxW-1:0] RegDevAddr = 2'd0;
  localparam logic [CfgIdxW-1:0] RegTicks   = 2'd1;
  localparam logic [CfgIdxW-1:0] RegAckLim  = 2'd2;

  // unused action code, the block treats it as a plain tick
  localparam logic [1:0] ActSpare = 2'd3;

  // bus timing and acknowledge limit per random phase
  localparam int unsigned PhaseTicks [NumPhases] = '{1, 2, 1, 3, 0, 1, 4, 2};
  localparam int unsigned PhaseLimit [NumPhases] = '{255, 0, 3, 1, 255, 2, 0, 8};

  // fixed line states that can be read straight off the sequence
  localparam res_t IdleRes = '{ack_error: 1'b0, read_data: 8'h00, done_res: 1'b0,
                               busy_res: 1'b0, sda_pull_low: 1'b0, scl_level: 1'b1};
  localparam res_t IdleErrRes = '{ack_error: 1'b1, read_data: 8'h00, done_res: 1'b0,
                                  busy_res: 1'b0, sda_pull_low: 1'b0, scl_level: 1'b1};
  localparam res_t StartRes = '{ack_error: 1'b0, read_data: 8'h00, done_res: 1'b0,
                                busy_res: 1'b1, sda_pull_low: 1'b0, scl_level: 1'b1};
  localparam res_t StartHeldRes = '{ack_error: 1'b0, read_data: 8'h00, done_res: 1'b0,
                                    busy_res: 1'b1, sda_pull_low: 1'b1, scl_level: 1'b1};

  typedef enum logic [4:0] {
    SqIdle, SqStart, SqSendDevW, SqAckDevW, SqSendReg, SqAckReg, SqSendData, SqAckData,
    SqRestart, SqSendDevR, SqAckDevR, SqRecv, SqNack, SqStop
  } seq_e;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] reg_addr;
    logic [7:0] wdata;
    logic       sda;
  } req_t;

  typedef enum logic [1:0] {RowReq, RowCfg, RowRun} row_e;

  // one directed step: a request, a register write, or ticks until idle
  // for a run row, val is the chance in percent that the target acknowledges a poll
  typedef struct {
    row_e                kind;
    req_t                req;
    logic [CfgIdxW-1:0]  idx;
    int unsigned         val;
    bit                  typed;
    res_t                want;
  } row_t;

  logic                clk_i;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [SDataW-1:0]   s_axis_tdata  = '0;
  logic [SUserW-1:0]   s_axis_tuser  = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [MDataW-1:0]   m_axis_tdata;
  logic                cfg_valid_i   = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i   = '0;
  logic [CfgDataW-1:0] cfg_data_i    = '0;

  // predictor copy of the registers and the sequencer
  cfg_t       bus_cfg  = '{DevAddrRst, TicksRst, AckLimRst};
  seq_e       sq       = SqIdle;
  logic [15:0] ph_cnt  = '0;
  logic [1:0] qtr      = '0;
  logic [3:0] bit_cnt  = '0;
  logic [7:0] shreg    = '0;
  logic [7:0] polls    = '0;
  logic [7:0] lat_reg  = '0;
  logic [7:0] lat_data = '0;
  logic       rd_mode  = 1'b0;
  logic [7:0] rx_byte  = '0;
  logic       err      = 1'b0;

  res_t        line_state_q[$];
  int unsigned mismatch_cnt = 0;
  int unsigned tick_cnt     = 0;
  int unsigned checked_cnt  = 0;
  int unsigned txn_cnt      = 0;
  int unsigned txn_err_cnt  = 0;
  bit          no_gaps      = 1'b0;
  bit          stall_req    = 1'b0;

  i2c_register_access_master i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  // sequencer helpers
  function automatic void enter_state(input seq_e s);
    sq      = s;
    ph_cnt  = '0;
    qtr     = '0;
    bit_cnt = '0;
    polls   = '0;
  endfunction

  function automatic void load_byte(input seq_e s, input logic [7:0] b);
    enter_state(s);
    shreg = b;
  endfunction

  function automatic bit phase_done();
    logic [15:0] len;
    len    = (bus_cfg.ticks_per_phase != 0) ? bus_cfg.ticks_per_phase : 16'd1;
    ph_cnt = ph_cnt + 16'd1;
    if (ph_cnt >= len) begin
      ph_cnt = '0;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  // true when the fourth quarter of a bit slot has finished
  function automatic bit slot_done();
    if (!phase_done()) return 1'b0;
    if (qtr < 2'd3) begin
      qtr++;
      return 1'b0;
    end
    qtr = '0;
    return 1'b1;
  endfunction

  // one bus tick: advance the sequence and return the line state after it
  function automatic res_t bus_tick(input req_t r);
    res_t        o;
    logic [15:0] len;
    logic        done;
    len  = (bus_cfg.ticks_per_phase != 0) ? bus_cfg.ticks_per_phase : 16'd1;
    done = 1'b0;
    case (sq)
      SqIdle: begin
        if (r.action == ActWrite || r.action == ActRead) begin
          lat_reg  = r.reg_addr;
          lat_data = r.wdata;
          rd_mode  = (r.action == ActRead);
          err      = 1'b0;
          enter_state(SqStart);
        end
      end
      SqStart: if (slot_done()) load_byte(SqSendDevW, {bus_cfg.device_address, 1'b0});
      SqSendDevW, SqSendReg, SqSendData, SqSendDevR: begin
        if (slot_done()) begin
          shreg = shreg << 1;
          bit_cnt++;
          if (bit_cnt >= 4'd8) begin
            sq      = seq_e'(sq + 5'd1);
            bit_cnt = '0;
            polls   = '0;
            ph_cnt  = '0;
            qtr     = '0;
          end
        end
      end
      SqAckDevW, SqAckReg, SqAckData, SqAckDevR: begin
        // scl held high in the third quarter while the target is polled
        if (qtr == 2'd2) begin
          if (!r.sda) begin
            qtr    = 2'd3;
            ph_cnt = '0;
          end else if (polls >= bus_cfg.ack_timeout_limit) begin
            err = 1'b1;
            enter_state(SqStop);
          end else begin
            polls++;
          end
        end else if (qtr == 2'd3) begin
          if (phase_done()) begin
            case (sq)
              SqAckDevW: load_byte(SqSendReg, lat_reg);
              SqAckReg: begin
                if (rd_mode) enter_state(SqRestart);
                else load_byte(SqSendData, lat_data);
              end
              SqAckData: enter_state(SqStop);
              default: load_byte(SqRecv, 8'h00);
            endcase
          end
        end else if (phase_done()) begin
          qtr++;
        end
      end
      SqRestart: if (slot_done()) load_byte(SqSendDevR, {bus_cfg.device_address, 1'b1});
      SqRecv: begin
        // data bit taken on the last tick of the second quarter
        if (qtr == 2'd1 && 17'(ph_cnt) + 17'd1 >= 17'(len)) shreg = {shreg[6:0], r.sda};
        if (slot_done()) begin
          bit_cnt++;
          if (bit_cnt >= 4'd8) begin
            rx_byte = shreg;
            enter_state(SqNack);
          end
        end
      end
      SqNack: if (slot_done()) enter_state(SqStop);
      SqStop: begin
        if (slot_done()) begin
          enter_state(SqIdle);
          done = 1'b1;
        end
      end
      default: enter_state(SqIdle);
    endcase

    // line levels for the new state
    o           = '0;
    o.busy_res  = (sq != SqIdle);
    o.done_res  = done;
    o.read_data = rx_byte;
    o.ack_error = err;
    case (sq)
      SqIdle: begin
        o.scl_level    = 1'b1;
        o.sda_pull_low = 1'b0;
      end
      SqStart: begin
        o.scl_level    = (qtr != 2'd3);
        o.sda_pull_low = (qtr != 2'd0);
      end
      SqSendDevW, SqSendReg, SqSendData, SqSendDevR: begin
        o.scl_level    = (qtr == 2'd1 || qtr == 2'd2);
        o.sda_pull_low = ~shreg[7];
      end
      SqRestart: begin
        o.scl_level    = (qtr == 2'd1 || qtr == 2'd2);
        o.sda_pull_low = (qtr >= 2'd2);
      end
      SqStop: begin
        o.scl_level    = (qtr >= 2'd2);
        o.sda_pull_low = (qtr == 2'd1 || qtr == 2'd2);
      end
      default: begin
        o.scl_level    = (qtr == 2'd1 || qtr == 2'd2);
        o.sda_pull_low = 1'b0;
      end
    endcase
    return o;
  endfunction

  // sda level the target drives next: acknowledge polls by chance, data bits at random
  function automatic logic target_sda(input int unsigned ack_pct);
    if ((sq == SqAckDevW || sq == SqAckReg || sq == SqAckData || sq == SqAckDevR) &&
        qtr == 2'd2)
      return ($urandom_range(99) < ack_pct) ? 1'b0 : 1'b1;
    return 1'($urandom_range(1));
  endfunction

  function automatic row_t req_row(input logic [1:0] act, input logic [7:0] ra,
                                   input logic [7:0] wd, input logic sda,
                                   input bit typed, input res_t want);
    row_t w;
    w.kind  = RowReq;
    w.req   = '{action: act, reg_addr: ra, wdata: wd, sda: sda};
    w.idx   = '0;
    w.val   = 0;
    w.typed = typed;
    w.want  = want;
    return w;
  endfunction

  function automatic row_t cfg_row(input logic [CfgIdxW-1:0] idx, input int unsigned val);
    row_t w;
    w       = req_row(ActTick, 8'h00, 8'h00, 1'b0, 1'b0, '0);
    w.kind  = RowCfg;
    w.idx   = idx;
    w.val   = val;
    return w;
  endfunction

  function automatic row_t run_row(input int unsigned ack_pct);
    row_t w;
    w      = req_row(ActTick, 8'h00, 8'h00, 1'b0, 1'b0, '0);
    w.kind = RowRun;
    w.val  = ack_pct;
    return w;
  endfunction

  task automatic note_mismatch(input string what, input logic [7:0] got,
                               input logic [7:0] want);
    mismatch_cnt++;
    if (mismatch_cnt <= MaxPrints)
      $display("%0t mismatch on %s: got %0h, want %0h", $time, what, got, want);
  endtask

  // offer one request, with random gaps, and predict its line state once taken
  task automatic send_req(input req_t r, input bit typed, input res_t want);
    res_t got;
    while (!no_gaps && $urandom_range(99) < IdlePct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= r.action;
    s_axis_tdata  <= {7'd0, r.sda, r.wdata, r.reg_addr};
    do @(posedge clk_i); while (!s_axis_tready);
    got = bus_tick(r);
    line_state_q.push_back(typed ? want : got);
    tick_cnt++;
  endtask

  // keep ticking until the sequencer is back in idle
  task automatic run_to_idle(input int unsigned ack_pct);
    req_t r;
    while (sq != SqIdle) begin
      r.action   = 2'($urandom_range(3));
      r.reg_addr = 8'($urandom);
      r.wdata    = 8'($urandom);
      r.sda      = target_sda(ack_pct);
      send_req(r, 1'b0, '0);
    end
  endtask

  // register write, only once the bus is idle and every result has drained
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [15:0] val);
    run_to_idle(100);
    s_axis_tvalid <= 1'b0;
    while (line_state_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    case (idx)
      RegDevAddr: bus_cfg.device_address    = val[6:0];
      RegTicks:   bus_cfg.ticks_per_phase   = val;
      RegAckLim:  bus_cfg.ack_timeout_limit = val[7:0];
      default: ;
    endcase
  endtask

  // clock
  initial begin : clock_gen
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // result side: random stalls, one long hold-off on request, field checks
  initial begin : result_sink
    int unsigned hold_left;
    res_t        got;
    res_t        want;
    hold_left = 0;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got = res_t'(m_axis_tdata[ResW-1:0]);
        checked_cnt++;
        if (got.done_res) begin
          txn_cnt++;
          if (got.ack_error) txn_err_cnt++;
        end
        if (line_state_q.size() == 0) begin
          note_mismatch("result with nothing pending", got.read_data, 8'h00);
        end else begin
          want = line_state_q.pop_front();
          if (got.scl_level !== want.scl_level)
            note_mismatch("scl_level", 8'(got.scl_level), 8'(want.scl_level));
          if (got.sda_pull_low !== want.sda_pull_low)
            note_mismatch("sda_pull_low", 8'(got.sda_pull_low), 8'(want.sda_pull_low));
          if (got.busy_res !== want.busy_res)
            note_mismatch("busy_res", 8'(got.busy_res), 8'(want.busy_res));
          if (got.done_res !== want.done_res)
            note_mismatch("done_res", 8'(got.done_res), 8'(want.done_res));
          if (got.read_data !== want.read_data)
            note_mismatch("read_data", got.read_data, want.read_data);
          if (got.ack_error !== want.ack_error)
            note_mismatch("ack_error", 8'(got.ack_error), 8'(want.ack_error));
        end
      end
      if (stall_req && hold_left == 0) begin
        hold_left = StallLen;
        stall_req = 1'b0;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= no_gaps || ($urandom_range(99) >= IdlePct);
      end
    end
  end

  // run limit
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  // stimulus: directed table, then random phases over several settings
  initial begin : stimulus
    row_t        rows[$];
    req_t        r;
    int unsigned roll;
    int unsigned counted;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset state, spare action, and starts ignored while busy
    rows.push_back(req_row(ActTick, 8'h00, 8'h00, 1'b0, 1'b1, IdleRes));
    rows.push_back(req_row(ActSpare, 8'hFF, 8'hFF, 1'b1, 1'b1, IdleRes));
    rows.push_back(cfg_row(RegTicks, 1));
    rows.push_back(cfg_row(RegAckLim, 0));
    rows.push_back(req_row(ActWrite, 8'hFF, 8'hFF, 1'b1, 1'b1, StartRes));
    rows.push_back(req_row(ActRead, 8'h00, 8'h00, 1'b0, 1'b1, StartHeldRes));
    rows.push_back(req_row(ActWrite, 8'h00, 8'h00, 1'b0, 1'b1, StartHeldRes));
    // target never acknowledges: zero limit gives up on the first high poll
    rows.push_back(run_row(0));
    rows.push_back(req_row(ActTick, 8'h00, 8'h00, 1'b0, 1'b1, IdleErrRes));
    // full read and write at the address extremes, zero ticks acts as one
    rows.push_back(cfg_row(RegDevAddr, 0));
    rows.push_back(cfg_row(RegAckLim, 255));
    rows.push_back(req_row(ActRead, 8'h00, 8'h00, 1'b0, 1'b0, '0));
    rows.push_back(run_row(100));
    rows.push_back(cfg_row(RegDevAddr, 127));
    rows.push_back(cfg_row(RegTicks, 0));
    rows.push_back(req_row(ActWrite, 8'hFF, 8'h00, 1'b1, 1'b0, '0));
    rows.push_back(run_row(100));
    rows.push_back(req_row(ActRead, 8'hFF, 8'hFF, 1'b1, 1'b0, '0));
    rows.push_back(run_row(100));
    // read that times out keeps the previous read byte
    rows.push_back(cfg_row(RegTicks, 2));
    rows.push_back(cfg_row(RegAckLim, 1));
    rows.push_back(req_row(ActRead, 8'h5A, 8'hA5, 1'b0, 1'b0, '0));
    rows.push_back(run_row(0));
    rows.push_back(req_row(ActTick, 8'hFF, 8'hFF, 1'b1, 1'b0, '0));

    foreach (rows[i]) begin
      case (rows[i].kind)
        RowReq:  send_req(rows[i].req, rows[i].typed, rows[i].want);
        RowCfg:  write_reg(rows[i].idx, 16'(rows[i].val));
        default: run_to_idle(rows[i].val);
      endcase
    end

    // random phases: mostly real transactions, target acks most polls
    for (int unsigned p = 0; p < NumPhases; p++) begin
      write_reg(RegDevAddr, 16'($urandom_range(127)));
      write_reg(RegTicks, 16'(PhaseTicks[p]));
      write_reg(RegAckLim, 16'(PhaseLimit[p]));
      no_gaps = (p == 4);
      if (p == 2) stall_req = 1'b1;
      counted = 0;
      while (counted < PhaseItems) begin
        roll       = $urandom_range(99);
        r.reg_addr = 8'($urandom);
        r.wdata    = 8'($urandom);
        if (sq == SqIdle) begin
          if (roll < 30) r.action = ActWrite;
          else if (roll < 60) r.action = ActRead;
          else if (roll < 80) r.action = ActTick;
          else r.action = ActSpare;
        end else begin
          r.action = 2'($urandom_range(3));
        end
        r.sda = target_sda(80);
        if (sq != SqIdle || r.action == ActWrite || r.action == ActRead) counted++;
        send_req(r, 1'b0, '0);
      end
    end
    no_gaps = 1'b0;

    // slowest bus timing, idle ticks only
    write_reg(RegTicks, 16'hFFFF);
    repeat (20) begin
      r.action   = $urandom_range(1) ? ActTick : ActSpare;
      r.reg_addr = 8'($urandom);
      r.wdata    = 8'($urandom);
      r.sda      = 1'($urandom_range(1));
      send_req(r, 1'b0, '0);
    end

    // drain and settle
    s_axis_tvalid <= 1'b0;
    while (line_state_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    $display("%0d bus ticks sent, %0d results compared, %0d transactions ended (%0d on timeout)",
             tick_cnt, checked_cnt, txn_cnt, txn_err_cnt);
    $display("swept device address 0/127/random, 0 to 4 and 65535 ticks, ack limit 0 to 255");
    if (mismatch_cnt == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* filelist.f */
src/i2cram_pkg.sv
src/i2cram_cfg.sv
src/i2cram_core.sv
src/i2cram_out.sv
src/i2c_register_access_master.sv
tb/i2c_register_access_master_tb.sv
